FILE: hdl/gns_pkg.sv
// ----------------------------------------------------------------------------
// gns_pkg
// Shared constants for the 2-D gradient noise sampler: hash multipliers,
// sine polynomial coefficients, fixed-point units and register map.
// ----------------------------------------------------------------------------
package gns_pkg;

   // default table resolutions
   localparam int ANGLE_BITS_DEF  = 10;
   localparam int WEIGHT_BITS_DEF = 10;

   // corner hash multipliers
   localparam logic [31:0] HASH_M1 = 32'd3284157443;
   localparam logic [31:0] HASH_M2 = 32'd1911520717;
   localparam logic [31:0] HASH_M3 = 32'd2048419325;

   // quarter-wave sine polynomial, Q.16
   localparam logic [16:0] SIN_A = 17'd102944;
   localparam logic [15:0] SIN_B = 16'd42178;
   localparam logic [12:0] SIN_C = 13'd4770;

   // one in Q.16
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // register map: register index is paddr[2]
   localparam int          CSR_ADDR_W     = 3;
   localparam logic [0:0]  REG_NOISE_SEED = 1'b0;

endpackage

FILE: hdl/gradient_noise_sampler_2d_top.sv
// ----------------------------------------------------------------------------
// gradient_noise_sampler_2d_top
// One octave of 2-D gradient noise per pixel, fully pipelined.
// ----------------------------------------------------------------------------
// Usage
//   req channel: a word holds a pixel coordinate, an octave frequency
//   (UQ0.24) and an integer amplitude. rsp channel: a word holds the noise
//   sample times the amplitude, signed Q.16, saturated to 33 bits.
//   Both channels use valid/ready; a word moves when both are high.
//   APB-style port: noise_seed at byte address 0, written in the access
//   cycle; pready is tied high.
// Timing
//   A word accepted on req passes through 19 register stages (coordinate
//   multiply, three hash multiplies, the sine pipeline, dot products, two
//   lerps and the amplitude multiply) before it is presented on rsp.
//   One word per cycle is taken and delivered when rsp_ready stays high.
// Reset and stall
//   Reset empties the pipeline and clears noise_seed to zero.
//   When a result waits and rsp_ready is low the whole pipeline freezes and
//   req_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gradient_noise_sampler_2d_top #(
   parameter int ANGLE_BITS  = gns_pkg::ANGLE_BITS_DEF,
   parameter int WEIGHT_BITS = gns_pkg::WEIGHT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gns_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   // request
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [15:0]                     req_coord_x,
   input  logic [15:0]                     req_coord_y,
   input  logic [23:0]                     req_octave_frequency,
   input  logic [15:0]                     req_octave_amplitude,
   // response
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [32:0]              rsp_noise_value
);

   localparam int NS = 19;
   localparam logic [ANGLE_BITS-1:0] ANG_QTR = {2'b01, {(ANGLE_BITS-2){1'b0}}};

   logic          en;
   logic [NS:1]   vld_ff;
   logic [31:0]   seed_ff;
   logic          csr_wr;

   // pipeline payload
   logic [39:0]        prod_ff [2];
   logic [15:0]        amp_ff  [1:17];
   logic [15:0]        fr_ff   [2:11][2];
   logic [31:0]        ha_ff   [2:5][4];
   logic [31:0]        hb_ff   [2:4][4];
   logic [15:0]        t2_ff   [2];
   logic signed [37:0] pt_ff   [2];
   logic [15:0]        t3_ff   [2];
   logic [19:0]        p2_ff   [2];
   logic [19:0]        sr_ff   [2];
   logic [16:0]        uw_ff   [2];
   logic [16:0]        ua_ff   [4][2];
   logic               an_ff   [6:10][4][2];
   logic [16:0]        wq_ff   [2];
   logic [16:0]        w_ff    [11:15][2];
   logic signed [15:0] g_ff    [4][2];
   logic signed [33:0] pd_ff   [4][2];
   logic signed [19:0] n_ff    [4];
   logic signed [38:0] dl_ff   [2];
   logic signed [19:0] bs_ff   [2];
   logic signed [19:0] lv_ff   [2];
   logic signed [38:0] dv_ff;
   logic signed [19:0] bv_ff;
   logic signed [19:0] v_ff;
   logic signed [36:0] r_ff;
   logic signed [32:0] out_ff;

   // next values
   logic [31:0]        ha_in [4];
   logic [31:0]        hb_in [4];
   logic signed [37:0] pt_in [2];
   logic [16:0]        uw_in [2];
   logic [16:0]        ua_in [4][2];
   logic               an_in [4][2];
   logic signed [15:0] g_in  [4][2];
   logic signed [33:0] pd_in [4][2];
   logic [16:0]        w_in  [2];
   logic signed [32:0] out_in;

   // sine pipeline outputs
   logic [16:0] qa [4][2];
   logic [16:0] qw [2];

   // flow control: the whole pipe moves unless a result waits
   assign en        = !vld_ff[NS] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NS];
   assign rsp_noise_value = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-1:1], req_valid};
      end
   end

   // configuration register
   assign csr_wr = psel && penable && pwrite && (paddr[2] == gns_pkg::REG_NOISE_SEED);
   assign pready = 1'b1;
   assign prdata = (paddr[2] == gns_pkg::REG_NOISE_SEED) ? seed_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd0;
      end else if (csr_wr) begin
         seed_ff <= pwdata;
      end
   end

   // hash pre-add and fade first products, from the scaled coordinate
   always_comb begin
      logic [31:0]        cxc;
      logic [31:0]        cyc;
      logic [31:0]        comb_sum;
      logic signed [21:0] pf;
      for (int c = 0; c < 4; c++) begin
         cxc      = 32'(prod_ff[0][39:24]) + 32'(c % 2);
         cyc      = 32'(prod_ff[1][39:24]) + 32'(c / 2);
         comb_sum = seed_ff + cxc + cyc;
         ha_in[c] = cxc + comb_sum;
         hb_in[c] = cyc + comb_sum;
      end
      for (int a = 0; a < 2; a++) begin
         pf       = $signed(22'(prod_ff[a][23:8]) * 22'd6) - 22'sd983040;
         pt_in[a] = $signed(38'(pf)) * $signed({22'b0, prod_ff[a][23:8]});
      end
   end

   // fade clamp and weight index quantisation
   always_comb begin
      logic [16:0] f;
      for (int a = 0; a < 2; a++) begin
         f        = (sr_ff[a] > 20'(gns_pkg::ONE_Q16)) ? gns_pkg::ONE_Q16 : sr_ff[a][16:0];
         uw_in[a] = {f[16:16-WEIGHT_BITS], {(16-WEIGHT_BITS){1'b0}}};
      end
   end

   // gradient angle: quadrant fold into the quarter-wave argument
   always_comb begin
      logic [ANGLE_BITS-1:0] idx;
      logic [ANGLE_BITS-1:0] k;
      logic [15:0]           ur;
      for (int c = 0; c < 4; c++) begin
         for (int a = 0; a < 2; a++) begin
            idx = ha_ff[5][c][31 -: ANGLE_BITS];
            k   = (a == 0) ? idx + ANG_QTR : idx;
            ur  = {k[ANGLE_BITS-3:0], {(18-ANGLE_BITS){1'b0}}};
            ua_in[c][a] = k[ANGLE_BITS-2] ? gns_pkg::ONE_Q16 - 17'(ur) : 17'(ur);
            an_in[c][a] = k[ANGLE_BITS-1];
         end
      end
   end

   // gradient to Q.14 with sign, weight square, corner products
   always_comb begin
      logic [14:0]        s15;
      logic [16:0]        wsq;
      logic signed [17:0] d;
      for (int c = 0; c < 4; c++) begin
         for (int a = 0; a < 2; a++) begin
            s15 = 15'((18'(qa[c][a]) + 18'd2) >> 2);
            g_in[c][a] = an_ff[10][c][a] ? -$signed({1'b0, s15}) : $signed({1'b0, s15});
            d = $signed({2'b0, fr_ff[11][a]});
            if (((a == 0) ? (c % 2) : (c / 2)) != 0) begin
               d = d - 18'sd65536;
            end
            pd_in[c][a] = $signed(34'(d)) * $signed(34'(g_ff[c][a]));
         end
      end
      for (int a = 0; a < 2; a++) begin
         wsq     = 17'((34'(wq_ff[a]) * 34'(wq_ff[a])) >> 16);
         w_in[a] = (wsq > gns_pkg::ONE_Q16) ? gns_pkg::ONE_Q16 : wsq;
      end
   end

   // output saturation
   always_comb begin
      if (r_ff > 37'sd4294967295) begin
         out_in = 33'sd4294967295;
      end else if (r_ff < -37'sd4294967296) begin
         out_in = -33'sd4294967296;
      end else begin
         out_in = 33'(r_ff);
      end
   end

   // sine pipelines: two components for each corner, one weight per axis
   for (genvar c = 0; c < 4; c++) begin : g_corner
      for (genvar a = 0; a < 2; a++) begin : g_axis
         gns_qsine u_ang (
            .clock (clock),
            .en    (en),
            .u_in  (ua_ff[c][a]),
            .s_out (qa[c][a])
         );
      end
   end

   for (genvar a = 0; a < 2; a++) begin : g_weight
      gns_qsine u_wgt (
         .clock (clock),
         .en    (en),
         .u_in  (uw_ff[a]),
         .s_out (qw[a])
      );
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: scale coordinate
         prod_ff[0] <= 40'(req_coord_x) * 40'(req_octave_frequency);
         prod_ff[1] <= 40'(req_coord_y) * 40'(req_octave_frequency);
         amp_ff[1]  <= req_octave_amplitude;
         for (int s = 2; s <= 17; s++) begin
            amp_ff[s] <= amp_ff[s-1];
         end
         // fraction shift line
         fr_ff[2][0] <= prod_ff[0][23:8];
         fr_ff[2][1] <= prod_ff[1][23:8];
         for (int s = 3; s <= 11; s++) begin
            fr_ff[s] <= fr_ff[s-1];
         end
         // corner hash: add, multiply, xor-rotate-multiply twice
         for (int c = 0; c < 4; c++) begin
            ha_ff[2][c] <= ha_in[c];
            hb_ff[2][c] <= hb_in[c];
            ha_ff[3][c] <= ha_ff[2][c] * gns_pkg::HASH_M1;
            hb_ff[3][c] <= hb_ff[2][c];
            ha_ff[4][c] <= ha_ff[3][c];
            hb_ff[4][c] <= (hb_ff[3][c] ^ {ha_ff[3][c][15:0], ha_ff[3][c][31:16]})
                           * gns_pkg::HASH_M2;
            ha_ff[5][c] <= (ha_ff[4][c] ^ {hb_ff[4][c][15:0], hb_ff[4][c][31:16]})
                           * gns_pkg::HASH_M3;
         end
         // fade polynomial
         for (int a = 0; a < 2; a++) begin
            t2_ff[a] <= 16'((32'(prod_ff[a][23:8]) * 32'(prod_ff[a][23:8])) >> 16);
            pt_ff[a] <= pt_in[a];
            t3_ff[a] <= 16'((32'(t2_ff[a]) * 32'(fr_ff[2][a])) >> 16);
            p2_ff[a] <= 20'((pt_ff[a] >>> 16) + 38'sd655360);
            sr_ff[a] <= 20'((36'(t3_ff[a]) * 36'(p2_ff[a])) >> 16);
            uw_ff[a] <= uw_in[a];
            wq_ff[a] <= qw[a];
         end
         // angle arguments and sign shift line
         ua_ff     <= ua_in;
         an_ff[6]  <= an_in;
         for (int s = 7; s <= 10; s++) begin
            an_ff[s] <= an_ff[s-1];
         end
         // weights
         w_ff[11] <= w_in;
         for (int s = 12; s <= 15; s++) begin
            w_ff[s] <= w_ff[s-1];
         end
         // gradients, dot products, rounding to Q.16
         g_ff  <= g_in;
         pd_ff <= pd_in;
         for (int c = 0; c < 4; c++) begin
            n_ff[c] <= 20'((35'(pd_ff[c][0]) + 35'(pd_ff[c][1]) + 35'sd8192) >>> 14);
         end
         // blend along x, top row and bottom row
         for (int k = 0; k < 2; k++) begin
            dl_ff[k] <= $signed(39'(21'(n_ff[2*k+1]) - 21'(n_ff[2*k])))
                        * $signed(39'({1'b0, w_ff[13][0]}));
            bs_ff[k] <= n_ff[2*k];
            lv_ff[k] <= bs_ff[k] + 20'(dl_ff[k] >>> 16);
         end
         // blend along y
         dv_ff <= $signed(39'(21'(lv_ff[1]) - 21'(lv_ff[0])))
                  * $signed(39'({1'b0, w_ff[15][1]}));
         bv_ff <= lv_ff[0];
         v_ff  <= bv_ff + 20'(dv_ff >>> 16);
         // amplitude and saturation
         r_ff   <= $signed(37'(v_ff)) * $signed({21'b0, amp_ff[17]});
         out_ff <= out_in;
      end
   end

   // a frozen pipe keeps its occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline occupancy changed during stall");

   // a waiting result blocks new requests
   a_block_on_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result waits");

   // seed write lands
   a_seed_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> seed_ff == $past(pwdata))
      else $error("noise seed write lost");

endmodule

FILE: hdl/gns_qsine.sv
// ----------------------------------------------------------------------------
// gns_qsine
// Pipelined quarter-wave sine: sin(pi/2 * u), u and result in Q.16.
// Four register stages, one multiply per stage, advances when en is high.
// ----------------------------------------------------------------------------
module gns_qsine (
   input  logic        clock,
   input  logic        en,
   input  logic [16:0] u_in,
   output logic [16:0] s_out
);

   logic [16:0] u1_ff, u2_ff, u3_ff;
   logic [16:0] sq1_ff, sq2_ff;
   logic [12:0] t1_ff;
   logic [15:0] t3_ff;
   logic [16:0] t5_ff;

   // u^2, then the nested polynomial one product at a time
   always_ff @(posedge clock) begin
      if (en) begin
         sq1_ff <= 17'((34'(u_in) * 34'(u_in)) >> 16);
         u1_ff  <= u_in;
         t1_ff  <= 13'((32'(gns_pkg::SIN_C) * 32'(sq1_ff)) >> 16);
         sq2_ff <= sq1_ff;
         u2_ff  <= u1_ff;
         t3_ff  <= 16'(((34'(gns_pkg::SIN_B) - 34'(t1_ff)) * 34'(sq2_ff)) >> 16);
         u3_ff  <= u2_ff;
         t5_ff  <= 17'(((35'(gns_pkg::SIN_A) - 35'(t3_ff)) * 35'(u3_ff)) >> 16);
      end
   end

   // clamp to one
   assign s_out = (t5_ff > gns_pkg::ONE_Q16) ? gns_pkg::ONE_Q16 : t5_ff;

endmodule
